// ===== rtl/kaf_pkg.sv =====
`default_nettype none
package kaf_pkg;

    localparam int COV_FRAC_BITS = 40;
    localparam int CFG_FRAC      = 24;
    localparam int CFG_SHL       = COV_FRAC_BITS - CFG_FRAC;
    localparam int COV_W         = 48;
    // dividend is |n| << COV_FRAC_BITS
    localparam int NUM_W         = COV_W + COV_FRAC_BITS;
    // remainder stays below |E| < 2^49
    localparam int REM_W         = 51;

    localparam logic [31:0] Q_ANGLE_RST = 32'd16777;
    localparam logic [31:0] Q_GYRO_RST  = 32'd83886;
    localparam logic [31:0] R_ANGLE_RST = 32'd8388608;
    localparam logic [31:0] DT_RST      = 32'd83886;

    localparam logic [1:0] CFG_Q_ANGLE = 2'd0;
    localparam logic [1:0] CFG_Q_GYRO  = 2'd1;
    localparam logic [1:0] CFG_R_ANGLE = 2'd2;
    localparam logic [1:0] CFG_DT      = 2'd3;

    typedef struct packed {
        logic               is_div;
        logic               shr_cov;   // shift by COV_FRAC_BITS, else by CFG_FRAC
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_arith_req;

    function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
        logic [17:0] top;
        top = v[64:47];
        if ((&top) || !(|top)) begin
            return v[47:0];
        end else if (v[64]) begin
            return {1'b1, 47'd0};
        end else begin
            return {1'b0, {47{1'b1}}};
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic [33:0] top;
        top = v[64:31];
        if ((&top) || !(|top)) begin
            return v[31:0];
        end else if (v[64]) begin
            return {1'b1, 31'd0};
        end else begin
            return {1'b0, {31{1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kaf_arith.sv =====
`default_nettype none
module kaf_arith
    import kaf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_arith_req         i_req,
    output logic                    o_done,
    output logic signed [63:0]      o_res
);

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {A_IDLE, A_MUL, A_RND, A_DIV, A_DFIN} t_ast;

    t_ast                r_st;
    logic                r_neg;
    logic                r_shr_cov;
    logic [63:0]         r_ma;
    logic [63:0]         r_mb;
    logic [1:0]          r_idx;
    logic [127:0]        r_acc;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_q;
    logic [REM_W-1:0]    r_rem;
    logic [REM_W-1:0]    r_md;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;
    logic signed [63:0]  r_res;

    logic [63:0]         abs_a;
    logic [63:0]         abs_b;
    logic [79:0]         part;
    logic [127:0]        part_sh;
    logic [127:0]        rnd;
    logic [127:0]        shd;
    logic [61:0]         mmag;
    logic [REM_W-1:0]    trial;
    logic                qb;
    logic [47:0]         dmag;

    always_comb begin
        abs_a   = i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
        abs_b   = i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);
        part    = r_ma * r_mb[16*r_idx +: 16];
        part_sh = {48'd0, part} << (16 * r_idx);
        if (r_shr_cov) begin
            rnd = r_acc + (128'd1 << (COV_FRAC_BITS - 1));
            shd = rnd >> COV_FRAC_BITS;
        end else begin
            rnd = r_acc + (128'd1 << (CFG_FRAC - 1));
            shd = rnd >> CFG_FRAC;
        end
        if (|shd[127:61]) begin
            mmag = r_neg ? {1'b1, 61'd0} : {1'b0, {61{1'b1}}};
        end else begin
            mmag = shd[61:0];
        end
        trial = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
        qb    = (trial >= r_md);
        // quotient clamp to the 48-bit signed range
        if (r_neg) begin
            dmag = (|r_q[NUM_W-1:47]) ? {1'b1, 47'd0} : r_q[47:0];
        end else begin
            dmag = (|r_q[NUM_W-1:47]) ? {1'b0, {47{1'b1}}} : r_q[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= A_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                A_IDLE: begin
                    if (i_start) begin
                        r_neg     <= i_req.a[63] ^ i_req.b[63];
                        r_shr_cov <= i_req.shr_cov;
                        r_ma      <= abs_a;
                        r_mb      <= abs_b;
                        r_idx     <= 2'd0;
                        r_acc     <= '0;
                        r_num     <= {abs_a[COV_W-1:0], {COV_FRAC_BITS{1'b0}}};
                        r_md      <= abs_b[REM_W-1:0];
                        r_rem     <= '0;
                        r_q       <= '0;
                        r_cnt     <= '0;
                        r_st      <= i_req.is_div ? A_DIV : A_MUL;
                    end
                end
                A_MUL: begin
                    r_acc <= r_acc + part_sh;
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_st <= A_RND;
                    end
                end
                A_RND: begin
                    r_res  <= r_neg ? -$signed({2'b00, mmag}) : $signed({2'b00, mmag});
                    r_done <= 1'b1;
                    r_st   <= A_IDLE;
                end
                A_DIV: begin
                    r_rem <= qb ? trial - r_md : trial;
                    r_q   <= {r_q[NUM_W-2:0], qb};
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_st <= A_DFIN;
                    end
                end
                A_DFIN: begin
                    r_res  <= r_neg ? -$signed({16'd0, dmag}) : $signed({16'd0, dmag});
                    r_done <= 1'b1;
                    r_st   <= A_IDLE;
                end
                default: r_st <= A_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ===== rtl/kalman_angle_filter.sv =====
// Each input transaction runs through ten multiplies on a shared 64x16 multiplier,
// two bit-serial divides (both skipped when the innovation variance is zero) and a
// load of the output register. The input stalls while an item is in work, so a new
// item is taken only after the last one has been handed to the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) restores the default noise and period
// registers, zero bias and unit diagonal covariance.
`default_nettype none
module kalman_angle_filter
    import kaf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_accel_angle,
    input  wire logic signed [31:0] i_gyro_rate,
    input  wire logic signed [31:0] i_prior_angle,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_new_angle,
    output logic signed [31:0]      o_bias_estimate
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} t_st;
    typedef enum logic [3:0] {
        ST_ANG, ST_P00, ST_P01, ST_P11, ST_K0, ST_K1,
        ST_U00, ST_U01, ST_U10, ST_U11, ST_ANG2, ST_BIAS
    } t_step;

    t_st                 r_st;
    t_step               r_step;
    logic [31:0]         r_q_angle, r_q_gyro, r_r_angle, r_dt;
    logic signed [31:0]  r_acc, r_gyr, r_pri, r_ang, r_bias;
    logic signed [47:0]  r_p00, r_p01, r_p10, r_p11;
    logic signed [47:0]  r_n00, r_n01, r_n10, r_n11, r_k0, r_k1;
    logic signed [32:0]  r_err;
    logic signed [49:0]  r_e;
    logic                r_out_valid;
    logic signed [31:0]  r_out_ang, r_out_bias;

    t_arith_req          req;
    logic                start;
    logic                done;
    logic signed [63:0]  m;
    logic signed [64:0]  mx;
    logic signed [63:0]  dt64;
    logic                out_free;

    kaf_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .o_done  (done),
        .o_res   (m)
    );

    always_comb begin
        dt64        = $signed({32'd0, r_dt});
        mx          = {m[63], m};
        req.is_div  = 1'b0;
        req.shr_cov = 1'b1;
        req.a       = '0;
        req.b       = '0;
        case (r_step)
            ST_ANG: begin
                req.shr_cov = 1'b0;
                req.a = 64'(r_gyr) - 64'(r_bias);
                req.b = dt64;
            end
            ST_P00: begin
                req.shr_cov = 1'b0;
                req.a = ($signed({32'd0, r_q_angle}) <<< CFG_SHL) - 64'(r_p01) - 64'(r_p10);
                req.b = dt64;
            end
            ST_P01: begin
                req.shr_cov = 1'b0;
                req.a = -64'(r_p11);
                req.b = dt64;
            end
            ST_P11: begin
                req.shr_cov = 1'b0;
                req.a = $signed({32'd0, r_q_gyro}) <<< CFG_SHL;
                req.b = dt64;
            end
            ST_K0: begin
                req.is_div = 1'b1;
                req.a = 64'(r_n00);
                req.b = 64'(r_e);
            end
            ST_K1: begin
                req.is_div = 1'b1;
                req.a = 64'(r_n10);
                req.b = 64'(r_e);
            end
            ST_U00: begin req.a = 64'(r_k0); req.b = 64'(r_n00); end
            ST_U01: begin req.a = 64'(r_k0); req.b = 64'(r_n01); end
            ST_U10: begin req.a = 64'(r_k1); req.b = 64'(r_n00); end
            ST_U11: begin req.a = 64'(r_k1); req.b = 64'(r_n01); end
            ST_ANG2: begin req.a = 64'(r_k0); req.b = 64'(r_err); end
            ST_BIAS: begin req.a = 64'(r_k1); req.b = 64'(r_err); end
            default: ;
        endcase
        // zero innovation variance: gains are zero, divider skipped
        start    = (r_st == S_ISSUE) && !(req.is_div && (r_e == '0));
        out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_step      <= ST_ANG;
            r_out_valid <= 1'b0;
            r_q_angle   <= Q_ANGLE_RST;
            r_q_gyro    <= Q_GYRO_RST;
            r_r_angle   <= R_ANGLE_RST;
            r_dt        <= DT_RST;
            r_bias      <= '0;
            r_p00       <= {8'sd1, 40'd0};
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= {8'sd1, 40'd0};
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_Q_ANGLE: r_q_angle <= i_cfg_data;
                    CFG_Q_GYRO:  r_q_gyro  <= i_cfg_data;
                    CFG_R_ANGLE: r_r_angle <= i_cfg_data;
                    CFG_DT:      r_dt      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_st != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_acc  <= i_accel_angle;
                        r_gyr  <= i_gyro_rate;
                        r_pri  <= i_prior_angle;
                        r_step <= ST_ANG;
                        r_st   <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (start) begin
                        r_st <= S_WAIT;
                    end else if (r_step == ST_K0) begin
                        r_k0   <= '0;
                        r_step <= ST_K1;
                    end else begin
                        r_k1   <= '0;
                        r_step <= ST_U00;
                    end
                end
                S_WAIT: begin
                    if (done) begin
                        r_st   <= (r_step == ST_BIAS) ? S_OUT : S_ISSUE;
                        r_step <= (r_step == ST_BIAS) ? ST_ANG : t_step'(r_step + 4'd1);
                        case (r_step)
                            ST_ANG: r_ang <= sat32({{33{r_pri[31]}}, r_pri} + mx);
                            ST_P00: r_n00 <= sat48({{17{r_p00[47]}}, r_p00} + mx);
                            ST_P01: begin
                                r_n01 <= sat48({{17{r_p01[47]}}, r_p01} + mx);
                                r_n10 <= sat48({{17{r_p10[47]}}, r_p10} + mx);
                            end
                            ST_P11: begin
                                r_n11 <= sat48({{17{r_p11[47]}}, r_p11} + mx);
                                r_err <= 33'(r_acc) - 33'(r_ang);
                                r_e   <= $signed({2'b00, r_r_angle, {CFG_SHL{1'b0}}})
                                         + 50'(r_n00);
                            end
                            ST_K0:  r_k0  <= m[47:0];
                            ST_K1:  r_k1  <= m[47:0];
                            ST_U00: r_p00 <= sat48({{17{r_n00[47]}}, r_n00} - mx);
                            ST_U01: r_p01 <= sat48({{17{r_n01[47]}}, r_n01} - mx);
                            ST_U10: r_p10 <= sat48({{17{r_n10[47]}}, r_n10} - mx);
                            ST_U11: r_p11 <= sat48({{17{r_n11[47]}}, r_n11} - mx);
                            ST_ANG2: r_ang <= sat32({{33{r_ang[31]}}, r_ang} + mx);
                            ST_BIAS: r_bias <= sat32({{33{r_bias[31]}}, r_bias} + mx);
                            default: ;
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ang   <= r_ang;
                        r_out_bias  <= r_bias;
                        r_st        <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_st != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_new_angle     = r_out_ang;
    assign o_bias_estimate = r_out_bias;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken but block not busy");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && out_free) |=> o_out_valid)
        else $error("result not presented");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (r_st == S_WAIT))
        else $error("arith result with no step waiting");

endmodule
`default_nettype wire
